[rtl/apwbe_pkg.sv]
package apwbe_pkg;

   localparam int unsigned DATA_W     = 8;
   localparam int unsigned DUR_W      = 16;
   localparam int unsigned SEG_W      = 5;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_LONG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SHORT_WIDTH = 2'd1;
   localparam logic [1:0] REG_GAP_WIDTH   = 2'd2;

   localparam logic [DUR_W-1:0] LONG_WIDTH_RESET  = 16'd1200;
   localparam logic [DUR_W-1:0] SHORT_WIDTH_RESET = 16'd400;
   localparam logic [DUR_W-1:0] GAP_WIDTH_RESET   = 16'd15000;

   // segment numbers within one word
   localparam logic [SEG_W-1:0] SEG_LAST_PLAIN  = 5'd15;
   localparam logic [SEG_W-1:0] SEG_TRAIL_HIGH  = 5'd16;
   localparam logic [SEG_W-1:0] SEG_TRAIL_LOW   = 5'd17;
   localparam logic [SEG_W-1:0] SEG_GAP         = 5'd18;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              last_byte;
      logic [SEG_W-1:0]  last_seg;
   } apwbe_entry_type;

   typedef struct packed {
      logic [DUR_W-1:0] long_width;
      logic [DUR_W-1:0] short_width;
      logic [DUR_W-1:0] gap_width;
   } apwbe_cfg_type;

endpackage

[rtl/apwbe_if.sv]
interface apwbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface apwbe_rsp_if;
   logic        valid;
   logic        ready;
   logic        level;
   logic [15:0] duration;
   logic        end_of_item;
   logic        end_of_frame;

   modport source (output valid, output level, output duration, output end_of_item,
                   output end_of_frame, input ready);
   modport sink   (input valid, input level, input duration, input end_of_item,
                   input end_of_frame, output ready);
endinterface

[rtl/apwbe_front.sv]
module apwbe_front (
   input  logic                     clock,
   input  logic                     reset,
   apwbe_req_if.sink                req,
   output logic                     ent_valid,
   output apwbe_pkg::apwbe_entry_type ent,
   input  logic                     ent_ready
);
   import apwbe_pkg::*;

   logic            valid_ff, valid_in;
   apwbe_entry_type ent_ff, ent_in;

   assign req.ready = !valid_ff || ent_ready;

   always_comb begin
      valid_in = valid_ff;
      ent_in   = ent_ff;
      if (req.ready) begin
         valid_in = req.valid;
         if (req.valid) begin
            ent_in.data_byte = req.data_byte;
            ent_in.last_byte = req.last_byte;
            // classify: a closing word adds trailer bit and gap
            ent_in.last_seg  = req.last_byte ? SEG_GAP : SEG_LAST_PLAIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ent_ff <= ent_in;
   end

   assign ent_valid = valid_ff;
   assign ent       = ent_ff;
endmodule

[rtl/apwbe_queue.sv]
module apwbe_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_valid,
   input  apwbe_pkg::apwbe_entry_type wr_ent,
   output logic                       wr_ready,
   output logic                       rd_valid,
   output apwbe_pkg::apwbe_entry_type rd_ent,
   input  logic                       rd_pop
);
   import apwbe_pkg::*;

   apwbe_entry_type mem_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_ent   = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_ent;
      end
   end
endmodule

[rtl/apwbe_back.sv]
module apwbe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  apwbe_pkg::apwbe_cfg_type   cfg,
   input  logic                       ent_valid,
   input  apwbe_pkg::apwbe_entry_type ent,
   output logic                       ent_pop,
   apwbe_rsp_if.source                rsp
);
   import apwbe_pkg::*;

   logic [SEG_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic             level_ff, level_in;
   logic [DUR_W-1:0] dur_ff, dur_in;
   logic             eoi_ff, eoi_in;
   logic             eof_ff, eof_in;
   logic             advance, emit, last_seg, bit_val;

   assign advance  = !valid_ff || rsp.ready;
   assign emit     = ent_valid && advance;
   assign last_seg = (cnt_ff == ent.last_seg);
   assign ent_pop  = emit && last_seg;
   assign bit_val  = ent.data_byte[3'd7 - cnt_ff[3:1]];

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = rsp.ready ? 1'b0 : valid_ff;
      level_in = level_ff;
      dur_in   = dur_ff;
      eoi_in   = eoi_ff;
      eof_in   = eof_ff;
      if (emit) begin
         valid_in = 1'b1;
         cnt_in   = last_seg ? '0 : cnt_ff + 1'b1;
         eoi_in   = last_seg;
         eof_in   = (cnt_ff == SEG_GAP);
         if (cnt_ff[4] == 1'b0) begin
            // data bit: high then low, long side follows the bit value
            level_in = ~cnt_ff[0];
            dur_in   = (bit_val ^ cnt_ff[0]) ? cfg.long_width : cfg.short_width;
         end else begin
            unique case (cnt_ff)
               SEG_TRAIL_HIGH: begin
                  level_in = 1'b1;
                  dur_in   = cfg.long_width;
               end
               SEG_TRAIL_LOW: begin
                  level_in = 1'b0;
                  dur_in   = cfg.short_width;
               end
               default: begin
                  level_in = 1'b0;
                  dur_in   = cfg.gap_width;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      level_ff <= level_in;
      dur_ff   <= dur_in;
      eoi_ff   <= eoi_in;
      eof_ff   <= eof_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.level        = level_ff;
   assign rsp.duration     = dur_ff;
   assign rsp.end_of_item  = eoi_ff;
   assign rsp.end_of_frame = eof_ff;
endmodule

[rtl/ask_pulse_width_bit_encoder_unit.sv]
// Channel   Dir  Handshake          Contents
// req_chan  in   valid/ready        data_byte[7:0], last_byte
// rsp_chan  out  valid/ready        level, duration[15:0], end_of_item, end_of_frame
// csr       in   APB, pready high   long_width, short_width, gap_width at 0x0/0x4/0x8
//
// One segment word leaves per cycle while the receiver takes them: a byte gives 16
// segments, a closing byte 19, set by the segment counter of the back end.
// The first segment of a byte reaches the output through the front register, the
// queue and the output register, in that order.
// Reset is synchronous and active high; it clears handshake state and reloads
// the width registers with their defaults.
// Either side may stall on its own: the front register and a two-word queue keep
// taking bytes while the output register holds a word that is not yet taken.
module ask_pulse_width_bit_encoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   apwbe_req_if.sink                          req_chan,
   apwbe_rsp_if.source                        rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [apwbe_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [apwbe_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [apwbe_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                               pready
);
   import apwbe_pkg::*;

   // width registers; the user must write them only while the block is idle, the block does not enforce it
   apwbe_cfg_type   cfg_ff, cfg_in;
   logic            csr_wr;
   logic [1:0]      csr_idx;

   logic            fr_valid, fr_ready;
   apwbe_entry_type fr_ent;
   logic            q_valid, q_pop;
   apwbe_entry_type q_ent;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_LONG_WIDTH:  cfg_in.long_width  = pwdata[DUR_W-1:0];
            REG_SHORT_WIDTH: cfg_in.short_width = pwdata[DUR_W-1:0];
            REG_GAP_WIDTH:   cfg_in.gap_width   = pwdata[DUR_W-1:0];
            default:         cfg_in = cfg_ff;   // drop writes beyond the map
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LONG_WIDTH:  prdata = {{(CSR_DATA_W-DUR_W){1'b0}}, cfg_ff.long_width};
         REG_SHORT_WIDTH: prdata = {{(CSR_DATA_W-DUR_W){1'b0}}, cfg_ff.short_width};
         REG_GAP_WIDTH:   prdata = {{(CSR_DATA_W-DUR_W){1'b0}}, cfg_ff.gap_width};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_width  <= LONG_WIDTH_RESET;
         cfg_ff.short_width <= SHORT_WIDTH_RESET;
         cfg_ff.gap_width   <= GAP_WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify each byte
   apwbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .ent_valid (fr_valid),
      .ent       (fr_ent),
      .ent_ready (fr_ready)
   );

   // decouple front and back
   apwbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ent   (fr_ent),
      .wr_ready (fr_ready),
      .rd_valid (q_valid),
      .rd_ent   (q_ent),
      .rd_pop   (q_pop)
   );

   // back: step through the segments of the head byte
   apwbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ent_valid (q_valid),
      .ent       (q_ent),
      .ent_pop   (q_pop),
      .rsp       (rsp_chan)
   );
endmodule

[rtl/apwbe_checker.sv]
module apwbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_level,
   input logic [15:0] rsp_duration,
   input logic        rsp_end_of_item,
   input logic        rsp_end_of_frame,
   input logic        pready
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duration) && $stable(rsp_level))
      else $error("stalled rsp word changed");

   // a frame closes on a low gap that also ends its byte
   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_item && !rsp_level)
      else $error("end_of_frame on a bad segment");

   // every byte ends on a low segment
   a_eoi_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_item |-> !rsp_level)
      else $error("end_of_item on a high segment");

   // output empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule

bind ask_pulse_width_bit_encoder_unit apwbe_checker u_apwbe_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_level        (rsp_chan.level),
   .rsp_duration     (rsp_chan.duration),
   .rsp_end_of_item  (rsp_chan.end_of_item),
   .rsp_end_of_frame (rsp_chan.end_of_frame),
   .pready           (pready)
);

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import apwbe_pkg::*;

   // Idle-cycle budget: the longest correct quiet stretch is the receiver hold-off
   // plus the pipeline latency, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PRINT_CAP      = 30;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_WORDS    = 26;
   localparam int HOLD_WORDS     = 8;
   localparam int MAX_FRAME      = 5;

   // Address slot past the register list; writes there must be dropped.
   localparam logic [1:0] REG_NONE = 2'd3;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;
      logic         is_last;
      logic [1:0]   reg_idx;
      logic [31:0]  wdata;
      logic         typed;
      logic [15:0]  dur_first;
      logic [15:0]  dur_final;
   } plan_row_type;

   typedef struct packed {
      logic        level;
      logic [15:0] duration;
      logic        end_of_item;
      logic        end_of_frame;
   } segment_type;

   // Directed plan. Typed rows carry the first and final segment durations as read
   // straight off the encoding rules; all other segments come from the predictor.
   localparam int PLAN_ROWS = 22;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // reset widths: all ones, all zeros, lone top bit closing a frame, lone bottom bit
      '{ROW_WORD, 8'hFF, 1'b0, REG_LONG_WIDTH, 32'h0, 1'b1, LONG_WIDTH_RESET, SHORT_WIDTH_RESET},
      '{ROW_WORD, 8'h00, 1'b0, REG_LONG_WIDTH, 32'h0, 1'b1, SHORT_WIDTH_RESET, LONG_WIDTH_RESET},
      '{ROW_WORD, 8'h80, 1'b1, REG_LONG_WIDTH, 32'h0, 1'b1, LONG_WIDTH_RESET, GAP_WIDTH_RESET},
      '{ROW_WORD, 8'h01, 1'b1, REG_LONG_WIDTH, 32'h0, 1'b1, SHORT_WIDTH_RESET, GAP_WIDTH_RESET},
      '{ROW_WORD, 8'hA5, 1'b0, REG_LONG_WIDTH, 32'h0, 1'b0, 16'd0, 16'd0},
      '{ROW_WORD, 8'h5A, 1'b1, REG_LONG_WIDTH, 32'h0, 1'b0, 16'd0, 16'd0},
      // widest and narrowest widths; upper data bits must be dropped
      '{ROW_CSR,  8'h00, 1'b0, REG_LONG_WIDTH,  32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0},
      '{ROW_CSR,  8'h00, 1'b0, REG_SHORT_WIDTH, 32'h0000_0001, 1'b0, 16'd0, 16'd0},
      '{ROW_CSR,  8'h00, 1'b0, REG_GAP_WIDTH,   32'h0000_FFFF, 1'b0, 16'd0, 16'd0},
      '{ROW_WORD, 8'hFF, 1'b1, REG_LONG_WIDTH, 32'h0, 1'b1, 16'hFFFF, 16'hFFFF},
      '{ROW_WORD, 8'h00, 1'b0, REG_LONG_WIDTH, 32'h0, 1'b1, 16'h0001, 16'hFFFF},
      // zero widths pass through as zero durations
      '{ROW_CSR,  8'h00, 1'b0, REG_LONG_WIDTH,  32'h0, 1'b0, 16'd0, 16'd0},
      '{ROW_CSR,  8'h00, 1'b0, REG_SHORT_WIDTH, 32'h0, 1'b0, 16'd0, 16'd0},
      '{ROW_CSR,  8'h00, 1'b0, REG_GAP_WIDTH,   32'h0, 1'b0, 16'd0, 16'd0},
      '{ROW_WORD, 8'h3C, 1'b1, REG_LONG_WIDTH, 32'h0, 1'b1, 16'd0, 16'd0},
      // write past the register list: no register may change
      '{ROW_CSR,  8'h00, 1'b0, REG_NONE, 32'h0000_1234, 1'b0, 16'd0, 16'd0},
      '{ROW_WORD, 8'hC3, 1'b0, REG_LONG_WIDTH, 32'h0, 1'b1, 16'd0, 16'd0},
      // long narrower than short
      '{ROW_CSR,  8'h00, 1'b0, REG_LONG_WIDTH,  32'h0000_0001, 1'b0, 16'd0, 16'd0},
      '{ROW_CSR,  8'h00, 1'b0, REG_SHORT_WIDTH, 32'hA5A5_FFFF, 1'b0, 16'd0, 16'd0},
      '{ROW_CSR,  8'h00, 1'b0, REG_GAP_WIDTH,   32'h0000_0001, 1'b0, 16'd0, 16'd0},
      '{ROW_WORD, 8'h7E, 1'b1, REG_LONG_WIDTH, 32'h0, 1'b1, 16'hFFFF, 16'h0001},
      '{ROW_WORD, 8'h81, 1'b0, REG_LONG_WIDTH, 32'h0, 1'b0, 16'd0, 16'd0}
   };

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   apwbe_req_if req_bus ();
   apwbe_rsp_if rsp_bus ();

   // Local copy of the width registers, as the block should hold them.
   apwbe_cfg_type widths;

   segment_type  segment_q [$];       // segments still owed by the block, oldest first
   plan_row_type pending_word_q [$];  // words offered but not yet accepted

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_pending   = 1'b0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   ask_pulse_width_bit_encoder_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Expand one accepted word into its segments: two per data bit, most significant
   // bit first, then the trailing one bit and the gap when the word closes a frame.
   function automatic void encode_word(input logic [7:0] data, input logic is_last,
                                       input plan_row_type plan);
      segment_type seg;
      int          base;
      base = segment_q.size();
      for (int b = 7; b >= 0; b--) begin
         seg = '{1'b1, data[b] ? widths.long_width : widths.short_width, 1'b0, 1'b0};
         segment_q.push_back(seg);
         seg = '{1'b0, data[b] ? widths.short_width : widths.long_width, 1'b0, 1'b0};
         segment_q.push_back(seg);
      end
      if (is_last) begin
         seg = '{1'b1, widths.long_width, 1'b0, 1'b0};
         segment_q.push_back(seg);
         seg = '{1'b0, widths.short_width, 1'b0, 1'b0};
         segment_q.push_back(seg);
         // keep the trailer's low and the gap apart; they are never merged
         seg = '{1'b0, widths.gap_width, 1'b0, 1'b1};
         segment_q.push_back(seg);
      end
      segment_q[$].end_of_item = 1'b1;
      // typed rows override the ends with the hand-read durations
      if (plan.typed) begin
         segment_q[base].duration = plan.dur_first;
         segment_q[$].duration    = plan.dur_final;
      end
   endfunction

   function automatic logic [15:0] width_of(input logic [1:0] idx);
      case (idx)
         REG_LONG_WIDTH:  return widths.long_width;
         REG_SHORT_WIDTH: return widths.short_width;
         default:         return widths.gap_width;
      endcase
   endfunction

   function automatic logic [15:0] pick_width();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'hFFFF;
         3:       return 16'($urandom_range(64, 1));
         default: return 16'($urandom_range(65535, 1));
      endcase
   endfunction

   // Check the response side first, then predict for the word accepted at this edge,
   // so both happen in one place in a fixed order.
   always @(posedge clock) begin : monitor
      segment_type  got;
      segment_type  want;
      plan_row_type plan;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.level, rsp_bus.duration, rsp_bus.end_of_item,
                    rsp_bus.end_of_frame};
            if (segment_q.size() == 0) begin
               if (mismatch_count < PRINT_CAP)
                  $display("%0t: unexpected segment lvl=%0d dur=%0d eoi=%0d eof=%0d",
                           $time, got.level, got.duration, got.end_of_item,
                           got.end_of_frame);
               mismatch_count++;
            end else begin
               want = segment_q.pop_front();
               if (got !== want) begin
                  if (mismatch_count < PRINT_CAP)
                     $display({"%0t: segment mismatch, expected lvl=%0d dur=%0d eoi=%0d ",
                               "eof=%0d, actual lvl=%0d dur=%0d eoi=%0d eof=%0d"},
                              $time, want.level, want.duration, want.end_of_item,
                              want.end_of_frame, got.level, got.duration,
                              got.end_of_item, got.end_of_frame);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            plan = (pending_word_q.size() != 0) ? pending_word_q.pop_front() : '0;
            encode_word(req_bus.data_byte, req_bus.last_byte, plan);
         end
      end
   end

   // Receiver: stall at the phase's rate; on request, hold off for a long stretch
   // counted here so the block backs up into its input.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || psel || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one word, idling first at the phase's rate, and hold it until taken.
   task automatic send_word(input plan_row_type row);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      pending_word_q.push_back(row);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= row.data;
      req_bus.last_byte <= row.is_last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and wait until every owed segment has come, then let the pipe settle.
   task automatic drain_words();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (segment_q.size() != 0 || pending_word_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup, access, then idle before the next.
   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (wr) begin
         case (idx)
            REG_LONG_WIDTH:  widths.long_width  = wdata[15:0];
            REG_SHORT_WIDTH: widths.short_width = wdata[15:0];
            REG_GAP_WIDTH:   widths.gap_width   = wdata[15:0];
            default: ;
         endcase
      end
      @(posedge clock);
   endtask

   // Write a register, then read back what it should now hold; after a write
   // past the list, read back all three.
   task automatic program_width(input logic [1:0] idx, input logic [31:0] wdata);
      logic [31:0] readback;
      csr_access(1'b1, idx, wdata, readback);
      for (int k = REG_LONG_WIDTH; k <= REG_GAP_WIDTH; k++) begin
         if (idx == REG_NONE || k == idx) begin
            csr_access(1'b0, 2'(k), 32'h0, readback);
            if (readback[15:0] !== width_of(2'(k))) begin
               if (mismatch_count < PRINT_CAP)
                  $display("%0t: register %0d readback, expected %0d, actual %0d",
                           $time, k, width_of(2'(k)), readback[15:0]);
               mismatch_count++;
            end
         end
      end
   endtask

   initial begin
      plan_row_type row;
      int           left;
      int           frame_len;

      // Drive every input to a known value from time zero.
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      widths = '{LONG_WIDTH_RESET, SHORT_WIDTH_RESET, GAP_WIDTH_RESET};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed plan; register rows only land on an idle block.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (DIRECTED_PLAN[i].kind == ROW_CSR) begin
            drain_words();
            program_width(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].wdata);
         end else begin
            send_word(DIRECTED_PLAN[i]);
         end
      end
      drain_words();

      // Back-pressure: stall the receiver for a long stretch while words keep coming,
      // then pause the sender until every segment is out.
      program_width(REG_LONG_WIDTH, 32'd3);
      program_width(REG_SHORT_WIDTH, 32'd1);
      program_width(REG_GAP_WIDTH, 32'd9);
      hold_pending = 1'b1;
      for (int i = 0; i < HOLD_WORDS; i++) begin
         row         = '0;
         row.kind    = ROW_WORD;
         row.data    = 8'($urandom);
         row.is_last = (i == HOLD_WORDS - 1);
         send_word(row);
      end
      drain_words();

      // Random frames over the idling phases: none, sender gaps, receiver stalls, both.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_words();
         program_width(REG_LONG_WIDTH, {16'($urandom), pick_width()});
         program_width(REG_SHORT_WIDTH, {16'($urandom), pick_width()});
         program_width(REG_GAP_WIDTH, {16'($urandom), pick_width()});
         if (ph == 1) program_width(REG_NONE, $urandom);
         case (ph)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         left = PHASE_WORDS;
         while (left > 0) begin
            frame_len = $urandom_range(MAX_FRAME, 1);
            if (frame_len > left) frame_len = left;
            for (int j = 0; j < frame_len; j++) begin
               row         = '0;
               row.kind    = ROW_WORD;
               row.data    = 8'($urandom);
               row.is_last = (j == frame_len - 1);
               send_word(row);
            end
            left -= frame_len;
         end
      end

      // Wait out everything owed, then settle once more for stray segments.
      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (segment_q.size() != 0) begin
         $display("%0t: %0d segments never arrived", $time, segment_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
